// ----- sv/shadowed_glyph_row_rasterizer_top_defines.svh -----
// Assertion macros shared by the checker of the glyph row rasterizer.
// No dependencies; included by the checker file.
`ifndef SHADOWED_GLYPH_ROW_RASTERIZER_TOP_DEFINES_SVH
`define SHADOWED_GLYPH_ROW_RASTERIZER_TOP_DEFINES_SVH

// Assertion disabled while reset is low.
`define SGRR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sgrr assertion failed");

// Assertion that also checks reset behavior.
`define SGRR_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sgrr assertion failed after reset");

`endif

// ----- sv/sgrr_pkg.sv -----
// Package for the glyph row rasterizer: beat type, field codes and sizes.
// No dependencies; used by sgrr_cell and the top level.
`timescale 1ns / 1ps

package sgrr_pkg;

    localparam int GLYPH_ROWS = 16;
    localparam int ASCII_W    = 8;
    localparam int BIG5_W     = 16;
    localparam int NUM_CELLS  = BIG5_W + 1;
    localparam int ADV_ASCII  = 8;
    localparam int ADV_UNDER  = 4;
    localparam int ADV_BIG5   = 16;

    localparam logic       CMD_BEGIN = 1'b0;
    localparam logic       CMD_ROW   = 1'b1;

    localparam logic [1:0] KIND_ASCII = 2'd0;
    localparam logic [1:0] KIND_UNDER = 2'd1;
    localparam logic [1:0] KIND_BIG5  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [3:0] ROW_LAST = 4'd15;

    localparam logic [1:0] CFG_FB_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FB_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_FG_COLOR  = 2'd2;
    localparam logic [1:0] CFG_SH_COLOR  = 2'd3;

    localparam logic STATUS_PIXEL  = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef struct packed {
        logic        v;
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  color;
        logic        status;
        logic        last;
    } t_beat;

endpackage

// ----- sv/sgrr_cell.sv -----
// One column cell of the output chain: holds one pending write beat.
// Depends on sgrr_pkg.
`timescale 1ns / 1ps

module sgrr_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  logic           i_shift,
    input  sgrr_pkg::t_beat i_load_beat,
    input  sgrr_pkg::t_beat i_next_beat,
    output sgrr_pkg::t_beat o_beat
);
    import sgrr_pkg::*;

    logic  r_v;
    t_beat r_pay;
    logic  n_v;
    t_beat n_pay;

    always_comb begin
        n_v   = r_v;
        n_pay = r_pay;
        if (i_load) begin
            n_v   = i_load_beat.v;
            n_pay = i_load_beat;
        end else if (i_shift) begin
            n_v   = i_next_beat.v;
            n_pay = i_next_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= n_v;
        end
        r_pay <= n_pay;
    end

    always_comb begin
        o_beat   = r_pay;
        o_beat.v = r_v;
    end

endmodule

// ----- sv/shadowed_glyph_row_rasterizer_top.sv -----
// Top level of the shadowed glyph row rasterizer: pen state, bounds check, cell chain.
// Depends on sgrr_pkg and sgrr_cell.
`timescale 1ns / 1ps

// Each glyph row is checked against the framebuffer when it is accepted and
// then loaded in parallel into a chain of 17 column cells, one per column of
// a 16-wide glyph plus the shadow column. The chain moves one cell toward the
// output register each cycle, and empty columns still pass through it. The
// next item is taken as soon as only the head cell remains and it moves out.
// A rejected glyph's status beat passes through the head cell and then the
// output register. Begin commands and rows that draw nothing are taken
// whenever the chain is free. Output stalls stop the chain; the output
// register lets the next row load while the final beat of the previous row
// waits.

module shadowed_glyph_row_rasterizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic signed [12:0] i_origin_x,
    input  logic signed [12:0] i_origin_y,
    input  logic [1:0]  i_glyph_kind,
    input  logic [3:0]  i_row_index,
    input  logic [15:0] i_row_bits,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_pixel_x,
    output logic [11:0] o_pixel_y,
    output logic [7:0]  o_pixel_color,
    output logic        o_status,
    output logic        o_last
);
    import sgrr_pkg::*;

    logic [12:0] r_fb_width;
    logic [12:0] r_fb_height;
    logic [7:0]  r_fg_color;
    logic [7:0]  r_sh_color;
    logic [12:0] r_pen_x;
    logic [12:0] r_line_y;
    logic        r_failed;
    logic        r_out_valid;
    t_beat       r_out;

    t_beat w_cell [NUM_CELLS];
    t_beat w_load [NUM_CELLS];
    t_beat w_next [NUM_CELLS];
    logic [NUM_CELLS-1:0] w_pix;
    logic [NUM_CELLS-1:0] w_fg;
    logic [NUM_CELLS-1:0] w_last;
    logic [NUM_CELLS-1:0] w_busy;

    logic        w_wide;
    logic        w_accept;
    logic        w_row_cmd;
    logic        w_load_en;
    logic        w_reject;
    logic        w_head_move;
    logic        w_shift;
    logic [13:0] w_x_end;
    logic [13:0] w_y_end;
    logic [11:0] w_y;
    logic [12:0] w_adv;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_width  <= 13'd320;
            r_fb_height <= 13'd200;
            r_fg_color  <= 8'd15;
            r_sh_color  <= 8'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FB_WIDTH:  r_fb_width  <= i_cfg_data;
                CFG_FB_HEIGHT: r_fb_height <= i_cfg_data;
                CFG_FG_COLOR:  r_fg_color  <= i_cfg_data[7:0];
                CFG_SH_COLOR:  r_sh_color  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Chain and handshake
    assign w_head_move = w_cell[0].v && (!r_out_valid || i_out_ready);
    assign w_shift     = !w_cell[0].v || w_head_move;
    assign o_in_ready  = !(|w_busy[NUM_CELLS-1:1]) && w_shift;
    assign w_accept    = i_in_valid && o_in_ready;

    assign w_wide    = (i_glyph_kind == KIND_BIG5);
    assign w_row_cmd = w_accept && (i_cmd == CMD_ROW) && !r_failed
                       && (i_glyph_kind != KIND_NONE);
    assign w_x_end   = {1'b0, r_pen_x} + (w_wide ? 14'(BIG5_W) : 14'(ASCII_W));
    assign w_y_end   = {1'b0, r_line_y} + 14'(GLYPH_ROWS);
    assign w_reject  = r_pen_x[12] || r_line_y[12]
                       || (w_x_end >= {1'b0, r_fb_width})
                       || (w_y_end > {1'b0, r_fb_height});
    assign w_load_en = w_row_cmd;
    assign w_y       = r_line_y[11:0] + {8'd0, i_row_index};

    always_comb begin
        case (i_glyph_kind)
            KIND_BIG5:  w_adv = 13'(ADV_BIG5);
            KIND_UNDER: w_adv = 13'(ADV_UNDER);
            default:    w_adv = 13'(ADV_ASCII);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x  <= '0;
            r_line_y <= '0;
            r_failed <= 1'b0;
        end else if (w_accept && (i_cmd == CMD_BEGIN)) begin
            r_pen_x  <= i_origin_x;
            r_line_y <= i_origin_y;
            r_failed <= 1'b0;
        end else if (w_row_cmd) begin
            if (w_reject) begin
                r_failed <= 1'b1;
            end else if (i_row_index == ROW_LAST) begin
                r_pen_x <= r_pen_x + w_adv;
            end
        end
    end

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_col
        logic fg;
        logic sh;
        if (c < BIG5_W) begin : g_fg
            assign fg = i_row_bits[BIG5_W-1-c] && (w_wide || (c < ASCII_W));
        end else begin : g_nofg
            assign fg = 1'b0;
        end
        if (c > 0) begin : g_sh
            assign sh = i_row_bits[BIG5_W-c] && (w_wide || (c <= ASCII_W));
        end else begin : g_nosh
            assign sh = 1'b0;
        end
        assign w_fg[c]  = fg;
        assign w_pix[c] = fg || sh;
        if (c < NUM_CELLS - 1) begin : g_lastn
            assign w_last[c] = w_pix[c] && !(|w_pix[NUM_CELLS-1:c+1]);
            assign w_next[c] = w_cell[c+1];
        end else begin : g_lastt
            assign w_last[c] = w_pix[c];
            assign w_next[c] = '0;
        end

        always_comb begin
            w_load[c] = '0;
            if (w_reject) begin
                if (c == 0) begin
                    w_load[c].v      = 1'b1;
                    w_load[c].status = STATUS_REJECT;
                    w_load[c].last   = 1'b1;
                end
            end else begin
                w_load[c].v      = w_pix[c];
                w_load[c].x      = r_pen_x[11:0] + 12'(c);
                w_load[c].y      = w_y;
                w_load[c].color  = w_fg[c] ? r_fg_color : r_sh_color;
                w_load[c].status = STATUS_PIXEL;
                w_load[c].last   = w_last[c];
            end
        end

        sgrr_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (w_load_en),
            .i_shift     (w_shift),
            .i_load_beat (w_load[c]),
            .i_next_beat (w_next[c]),
            .o_beat      (w_cell[c])
        );
        assign w_busy[c] = w_cell[c].v;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_head_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_head_move) begin
            r_out <= w_cell[0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_out.x;
    assign o_pixel_y     = r_out.y;
    assign o_pixel_color = r_out.color;
    assign o_status      = r_out.status;
    assign o_last        = r_out.last;

endmodule

// ----- sv/sgrr_checker.sv -----
// Port-level checker for the glyph row rasterizer, bound to the top level.
// Depends on shadowed_glyph_row_rasterizer_top_defines.svh.
`timescale 1ns / 1ps
`include "shadowed_glyph_row_rasterizer_top_defines.svh"

module sgrr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_cfg_ready,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [11:0] o_pixel_x,
    input logic [11:0] o_pixel_y,
    input logic [7:0]  o_pixel_color,
    input logic        o_status,
    input logic        o_last
);

    // stalled beat holds
    `SGRR_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_x) && $stable(o_pixel_y) && $stable(o_pixel_color) && $stable(o_status) && $stable(o_last))

    // reject beat is a lone, zeroed beat
    `SGRR_ASSERT(a_reject_form, i_clk, i_rst_n, o_out_valid && o_status |-> o_last && (o_pixel_x == 12'd0) && (o_pixel_y == 12'd0) && (o_pixel_color == 8'd0))

    `SGRR_ASSERT(a_cfg_ready, i_clk, i_rst_n, o_cfg_ready)

    // chain empties on reset
    `SGRR_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n ##1 !i_rst_n |=> o_in_ready && !o_out_valid)

endmodule

bind shadowed_glyph_row_rasterizer_top sgrr_checker u_sgrr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_cfg_ready   (o_cfg_ready),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pixel_x     (o_pixel_x),
    .o_pixel_y     (o_pixel_y),
    .o_pixel_color (o_pixel_color),
    .o_status      (o_status),
    .o_last        (o_last)
);

// ----- bench/testbench.sv -----
// Self-checking bench for shadowed_glyph_row_rasterizer_top: begin commands and glyph
// rows go through a driver queue, pixel writes are checked against an inline predictor.
// Depends on sgrr_pkg and the rasterizer RTL.
`timescale 1ns / 1ps

module testbench;
    import sgrr_pkg::*;

    typedef struct packed {
        logic        cmd;
        logic [12:0] ox;
        logic [12:0] oy;
        logic [1:0]  kind;
        logic [3:0]  row;
        logic [15:0] bits;
    } t_text_item;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  color;
        logic        status;
        logic        last;
    } t_pixel_wr;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = CFG_FB_WIDTH;
    logic [12:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_cmd = CMD_BEGIN;
    logic signed [12:0] i_origin_x = '0;
    logic signed [12:0] i_origin_y = '0;
    logic [1:0]         i_glyph_kind = KIND_ASCII;
    logic [3:0]         i_row_index = '0;
    logic [15:0]        i_row_bits = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [11:0]        o_pixel_x;
    logic [11:0]        o_pixel_y;
    logic [7:0]         o_pixel_color;
    logic               o_status;
    logic               o_last;

    // predictor state and register copies
    logic [12:0] pen_x = '0;
    logic [12:0] line_y = '0;
    logic        glyph_dead = 1'b0;
    logic [12:0] fb_w = 13'd320;
    logic [12:0] fb_h = 13'd200;
    logic [7:0]  fg_color = 8'd15;
    logic [7:0]  sh_color = 8'd0;

    t_text_item text_q[$];
    t_pixel_wr  pixel_q[$];
    int         mismatches = 0;
    int         snd_idle = 27;
    int         rcv_idle = 82;
    logic       in_taken = 1'b0;

    shadowed_glyph_row_rasterizer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_origin_x    (i_origin_x),
        .i_origin_y    (i_origin_y),
        .i_glyph_kind  (i_glyph_kind),
        .i_row_index   (i_row_index),
        .i_row_bits    (i_row_bits),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic log_mismatch(string what, int got, int want);
        $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Works out the pixel writes of one accepted beat and updates pen state.
    function automatic void rasterize(t_text_item it);
        int          px, py, w, adv;
        logic [15:0] bits;
        logic        fg, sh, held;
        t_pixel_wr   wr;
        if (it.cmd == CMD_BEGIN) begin
            pen_x = it.ox;
            line_y = it.oy;
            glyph_dead = 1'b0;
            return;
        end
        if (glyph_dead || it.kind == KIND_NONE) return;
        if (it.kind == KIND_BIG5) begin
            w = BIG5_W;
            bits = it.bits;
            adv = ADV_BIG5;
        end else begin
            w = ASCII_W;
            bits = {8'h00, it.bits[15:8]};
            adv = (it.kind == KIND_UNDER) ? ADV_UNDER : ADV_ASCII;
        end
        px = $signed(pen_x);
        py = $signed(line_y);
        if (px < 0 || py < 0 || px + w >= int'(fb_w) || py + GLYPH_ROWS > int'(fb_h)) begin
            wr = '0;
            wr.status = STATUS_REJECT;
            wr.last = 1'b1;
            pixel_q.push_back(wr);
            glyph_dead = 1'b1;
            return;
        end
        held = 1'b0;
        wr = '0;
        for (int c = 0; c <= w; c++) begin
            fg = 1'b0;
            sh = 1'b0;
            if (c < w) fg = bits[w - 1 - c];
            if (c >= 1) sh = bits[w - c];
            if (fg || sh) begin
                if (held) pixel_q.push_back(wr);
                wr.x = 12'(px + c);
                wr.y = 12'(py + int'(it.row));
                wr.color = fg ? fg_color : sh_color;
                wr.status = STATUS_PIXEL;
                wr.last = 1'b0;
                held = 1'b1;
            end
        end
        if (held) begin
            wr.last = 1'b1;
            pixel_q.push_back(wr);
        end
        if (it.row == ROW_LAST) pen_x = pen_x + 13'(adv);
    endfunction

    // driver: new beats and ready at the falling edge
    always @(negedge i_clk) begin : drive
        t_text_item it;
        if (i_rst_n !== 1'b1) begin
            i_in_valid <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rcv_idle);
            if (!i_in_valid || in_taken) begin
                if (text_q.size() != 0 && $urandom_range(99) >= snd_idle) begin
                    it = text_q.pop_front();
                    i_cmd <= it.cmd;
                    i_origin_x <= it.ox;
                    i_origin_y <= it.oy;
                    i_glyph_kind <= it.kind;
                    i_row_index <= it.row;
                    i_row_bits <= it.bits;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: predict on accepted input, check accepted writes
    always @(posedge i_clk) begin : watch
        t_pixel_wr want;
        if (i_rst_n !== 1'b1) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready)
                rasterize({i_cmd, i_origin_x, i_origin_y, i_glyph_kind, i_row_index,
                           i_row_bits});
            if (o_out_valid && i_out_ready) begin
                if (pixel_q.size() == 0) begin
                    log_mismatch("unexpected write beat", 1, 0);
                end else begin
                    want = pixel_q.pop_front();
                    if (o_pixel_x !== want.x) log_mismatch("pixel_x", o_pixel_x, want.x);
                    if (o_pixel_y !== want.y) log_mismatch("pixel_y", o_pixel_y, want.y);
                    if (o_pixel_color !== want.color)
                        log_mismatch("pixel_color", o_pixel_color, want.color);
                    if (o_status !== want.status) log_mismatch("status", o_status, want.status);
                    if (o_last !== want.last) log_mismatch("last", o_last, want.last);
                end
            end
        end
    end

    task automatic add_begin(logic [12:0] ox, logic [12:0] oy);
        t_text_item it;
        it.cmd = CMD_BEGIN;
        it.ox = ox;
        it.oy = oy;
        it.kind = 2'($urandom);
        it.row = 4'($urandom);
        it.bits = 16'($urandom);
        text_q.push_back(it);
    endtask

    task automatic add_row(logic [1:0] kind, logic [3:0] row, logic [15:0] bits);
        t_text_item it;
        it.cmd = CMD_ROW;
        it.ox = 13'($urandom);
        it.oy = 13'($urandom);
        it.kind = kind;
        it.row = row;
        it.bits = bits;
        text_q.push_back(it);
    endtask

    function automatic logic [15:0] glyph_bits();
        return ($urandom_range(4) == 0) ? 16'h0000 : 16'($urandom);
    endfunction

    // Mostly begin + glyph sequences with random rows; some noise and unterminated glyphs.
    task automatic queue_text(int n_draw);
        int         drawn, xmax, ymax;
        logic [1:0] kind;
        t_text_item it;
        drawn = 0;
        while (drawn < n_draw) begin
            if ($urandom_range(99) < 10) begin
                it.cmd = 1'($urandom);
                it.ox = 13'($urandom);
                it.oy = 13'($urandom);
                it.kind = 2'($urandom);
                it.row = 4'($urandom);
                it.bits = 16'($urandom);
                text_q.push_back(it);
                if (it.cmd == CMD_ROW && it.kind != KIND_NONE) drawn++;
            end else begin
                if ($urandom_range(9) < 8) begin
                    xmax = (fb_w > 13'd9) ? int'(fb_w) - 9 : 0;
                    ymax = (fb_h > 13'd16) ? int'(fb_h) - 16 : 0;
                    if (xmax > 4095) xmax = 4095;
                    if (ymax > 4095) ymax = 4095;
                    add_begin(13'($urandom_range(xmax)), 13'($urandom_range(ymax)));
                end else begin
                    add_begin(13'($urandom), 13'($urandom));
                end
                repeat ($urandom_range(4, 1)) begin
                    kind = ($urandom_range(19) == 0) ? KIND_NONE : 2'($urandom_range(2));
                    repeat ($urandom_range(3)) begin
                        add_row(kind, 4'($urandom_range(14)), glyph_bits());
                        drawn++;
                    end
                    if ($urandom_range(9) != 0) begin
                        add_row(kind, ROW_LAST, glyph_bits());
                        drawn++;
                    end
                end
            end
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_FB_WIDTH:  fb_w = data;
            CFG_FB_HEIGHT: fb_h = data;
            CFG_FG_COLOR:  fg_color = data[7:0];
            CFG_SH_COLOR:  sh_color = data[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(int w, int h, int fg, int sh);
        write_reg(CFG_FB_WIDTH, 13'(w));
        write_reg(CFG_FB_HEIGHT, 13'(h));
        write_reg(CFG_FG_COLOR, {5'($urandom), 8'(fg)});
        write_reg(CFG_SH_COLOR, {5'($urandom), 8'(sh)});
    endtask

    // wait for the sender to empty and every write to come back, then let the pipe go quiet
    task automatic settle();
        while (text_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset frame 320x200
        add_begin(13'd0, 13'd0);
        add_row(KIND_ASCII, 4'd0, 16'hFF00);
        add_row(KIND_ASCII, 4'd1, 16'h80FF);
        add_row(KIND_ASCII, 4'd2, 16'h0100);
        add_row(KIND_ASCII, 4'd3, 16'h00FF);
        add_row(KIND_NONE, ROW_LAST, 16'hFFFF);
        add_row(KIND_ASCII, ROW_LAST, 16'h5500);
        add_row(KIND_UNDER, ROW_LAST, 16'hAA00);
        add_row(KIND_BIG5, 4'd0, 16'hFFFF);
        add_row(KIND_BIG5, ROW_LAST, 16'h8001);
        add_begin(13'd303, 13'd184);
        add_row(KIND_BIG5, ROW_LAST, 16'hFFFF);
        add_row(KIND_ASCII, 4'd0, 16'hFF00);
        add_row(KIND_ASCII, 4'd0, 16'hFF00);
        add_begin(13'h1FFF, 13'd0);
        add_row(KIND_ASCII, 4'd0, 16'hFF00);
        add_begin(13'd0, 13'h1000);
        add_row(KIND_UNDER, 4'd4, 16'h8000);
        add_begin(13'd4095, 13'd4095);
        add_row(KIND_BIG5, 4'd0, 16'h0001);
        add_begin(13'd10, 13'd185);
        add_row(KIND_ASCII, 4'd0, 16'h0100);
        settle();

        // oversized frame: coordinate truncation and pen wrap
        set_frame(8191, 8191, 255, 170);
        add_begin(13'd4088, 13'd4095);
        add_row(KIND_ASCII, ROW_LAST, 16'hFF01);
        add_row(KIND_ASCII, 4'd0, 16'h8000);
        settle();

        for (int p = 0; p < 6; p++) begin
            snd_idle = (p < 2) ? 27 : (p < 4) ? 82 : 0;
            rcv_idle = (p < 2) ? 82 : (p < 4) ? 27 : 0;
            case (p)
                0: set_frame(320, 200, 15, 0);
                1: set_frame(4096, 4096, 255, 0);
                2: set_frame(16, 16, 0, 255);
                3: set_frame($urandom_range(4096, 17), $urandom_range(4096, 16),
                             $urandom_range(255), $urandom_range(255));
                4: set_frame(1, 1, $urandom_range(255), $urandom_range(255));
                default: set_frame(8191, 8191, $urandom_range(255), $urandom_range(255));
            endcase
            queue_text(14);
            settle();
            queue_text(14);
            settle();
        end

        if (pixel_q.size() != 0) log_mismatch("writes never seen", 0, pixel_q.size());
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/sgrr_pkg.sv
sv/sgrr_cell.sv
sv/shadowed_glyph_row_rasterizer_top.sv
sv/sgrr_checker.sv
bench/testbench.sv
